@@ hw/rtl/rqpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqpp_pkg
// shared types and codes for the ready queue priority picker
// ----------------------------------------------------------------------------
package rqpp_pkg;

  // action codes
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_PICK    = 1'b1;

  // status codes
  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_PICKED   = 3'd3;
  localparam logic [2:0] ST_RUN_IDLE = 3'd4;

  typedef struct packed {
    logic       action;
    logic [7:0] thread_id;
    logic [3:0] thread_priority;
    logic       any_core;
    logic [2:0] bound_core;
    logic [2:0] requesting_core;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] chosen_thread;
  } out_item_t;

  // one queued thread
  typedef struct packed {
    logic [7:0] thread_id;
    logic [3:0] prio;
    logic       any_core;
    logic [2:0] core;
  } entry_t;

  // best candidate so far, passed down the chain
  typedef struct packed {
    logic       found;
    logic [3:0] prio;
    logic [7:0] thread_id;
  } token_t;

  // per-cycle commands broadcast to all cells
  typedef struct packed {
    logic enq_write;
    logic remove;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/rqpp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqpp_cell
// one queue slot: holds an entry, compares it against the passing candidate
// ----------------------------------------------------------------------------
module rqpp_cell #(
  parameter int QUEUE_DEPTH = 16,
  parameter int IDX         = 0,
  localparam int IW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  rqpp_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  logic [IW-1:0]       sel_idx,
  input  logic [2:0]          req_core,
  input  rqpp_pkg::entry_t    new_entry,
  input  rqpp_pkg::entry_t    next_entry,
  input  rqpp_pkg::token_t    tok_in,
  input  logic [IW-1:0]       tok_in_idx,
  output rqpp_pkg::entry_t    entry,
  output rqpp_pkg::token_t    tok_out,
  output logic [IW-1:0]       tok_out_idx
);

  logic occupied;
  logic eligible;
  logic take;

  assign occupied = CW'(IDX) < count;
  assign eligible = occupied && (entry.any_core || (entry.core == req_core));
  // strict compare keeps the older entry on a tie
  assign take     = eligible && (!tok_in.found || (entry.prio > tok_in.prio));

  always_ff @(posedge clk) begin
    if (ctrl.enq_write && (count == CW'(IDX))) begin
      entry <= new_entry;
    end else if (ctrl.remove && (IW'(IDX) >= sel_idx)) begin
      entry <= next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_out.found     <= 1'b1;
      tok_out.prio      <= entry.prio;
      tok_out.thread_id <= entry.thread_id;
      tok_out_idx       <= IW'(IDX);
    end else begin
      tok_out     <= tok_in;
      tok_out_idx <= tok_in_idx;
    end
  end

endmodule

@@ hw/rtl/ready_queue_priority_picker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ready_queue_priority_picker
// ready queue of threads in arrival order with priority pick and core affinity
// ----------------------------------------------------------------------------
// enqueue: accepted when start is high and busy low, result strobed on the
//   next cycle, a new item may be accepted in that same cycle
// pick: busy through S_SCAN and S_DONE; S_DONE registers the result and the strobe
//   once the candidate has walked one cell per cycle down the whole chain
// reset (rst, synchronous): queue empty, idle_priority 0, no result pending
// results cannot be stalled; done marks each result for exactly one cycle
module ready_queue_priority_picker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  rqpp_pkg::in_item_t   cmd,
  // result channel
  output logic                 done,
  output rqpp_pkg::out_item_t  result,
  // idle priority register
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_data
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t          state;
  logic [IW-1:0]   scan_cnt;
  logic [CW-1:0]   count;
  logic [3:0]      idle_priority;
  logic [2:0]      req_core;

  logic            accept;
  logic            enq_acc;
  logic            pick_acc;
  logic            enq_drop;
  logic            enq_full;
  logic            scan_last;

  rqpp_pkg::cell_ctrl_t ctrl;
  rqpp_pkg::entry_t     new_entry;
  rqpp_pkg::entry_t     slot     [QUEUE_DEPTH];
  rqpp_pkg::token_t     tok      [QUEUE_DEPTH];
  logic [IW-1:0]        tok_idx  [QUEUE_DEPTH];
  rqpp_pkg::token_t     best;
  logic [IW-1:0]        best_idx;

  // ---- command decode ----
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign enq_acc  = accept && (cmd.action == rqpp_pkg::ACT_ENQUEUE);
  assign pick_acc = accept && (cmd.action == rqpp_pkg::ACT_PICK);
  assign enq_drop = cmd.thread_priority == idle_priority;
  assign enq_full = count == CW'(QUEUE_DEPTH);
  assign scan_last = scan_cnt == IW'(QUEUE_DEPTH - 1);

  assign new_entry.thread_id = cmd.thread_id;
  assign new_entry.prio      = cmd.thread_priority;
  assign new_entry.any_core  = cmd.any_core;
  assign new_entry.core      = cmd.bound_core;

  // last cell holds the winner once the candidate has crossed the whole chain
  assign best     = tok[QUEUE_DEPTH-1];
  assign best_idx = tok_idx[QUEUE_DEPTH-1];

  // new entry lands in the first free slot; removal pulls younger ones down
  assign ctrl.enq_write = enq_acc && !enq_drop && !enq_full;
  assign ctrl.remove    = (state == S_DONE) && best.found;

  // ---- slot chain ----
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    rqpp_pkg::token_t t_in;
    logic [IW-1:0]    t_in_idx;
    rqpp_pkg::entry_t nxt;

    if (k == 0) begin : g_head
      // chain starts with no candidate
      assign t_in     = '0;
      assign t_in_idx = '0;
    end else begin : g_body
      assign t_in     = tok[k-1];
      assign t_in_idx = tok_idx[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      // tail slot keeps stale data after a shift; it falls outside count
      assign nxt = slot[k];
    end else begin : g_mid
      assign nxt = slot[k+1];
    end

    rqpp_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX         (k)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .sel_idx     (best_idx),
      .req_core    (req_core),
      .new_entry   (new_entry),
      .next_entry  (nxt),
      .tok_in      (t_in),
      .tok_in_idx  (t_in_idx),
      .entry       (slot[k]),
      .tok_out     (tok[k]),
      .tok_out_idx (tok_idx[k])
    );
  end

  // ---- control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      scan_cnt      <= '0;
      count         <= '0;
      idle_priority <= 4'd0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        idle_priority <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (enq_acc) begin
            done <= 1'b1;
            if (ctrl.enq_write) begin
              count <= count + CW'(1);
            end
          end else if (pick_acc) begin
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // the candidate walks one cell per cycle down the chain
          scan_cnt <= scan_cnt + IW'(1);
          if (scan_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (ctrl.remove) begin
            count <= count - CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- payload ----
  always_ff @(posedge clk) begin
    if (pick_acc) begin
      req_core <= cmd.requesting_core;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      if (best.found) begin
        result.status        <= rqpp_pkg::ST_PICKED;
        result.chosen_thread <= best.thread_id;
      end else begin
        result.status        <= rqpp_pkg::ST_RUN_IDLE;
        result.chosen_thread <= 8'd0;
      end
    end else if (enq_acc) begin
      result.chosen_thread <= 8'd0;
      if (enq_drop) begin
        result.status <= rqpp_pkg::ST_DROPPED;
      end else if (enq_full) begin
        result.status <= rqpp_pkg::ST_FULL;
      end else begin
        result.status <= rqpp_pkg::ST_QUEUED;
      end
    end
  end

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("occupied count beyond queue depth");

  a_pick_busy: assert property (@(posedge clk) disable iff (rst)
    pick_acc |=> (busy && (state == S_SCAN)))
    else $error("pick did not start a scan");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_DONE || $past(enq_acc)))
    else $error("result strobe without a finished item");

  a_pick_pops: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == rqpp_pkg::ST_PICKED)) |-> (count == $past(count) - CW'(1)))
    else $error("picked entry not removed");

  a_queued_grows: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == rqpp_pkg::ST_QUEUED)) |-> (count == $past(count) + CW'(1)))
    else $error("queued entry not counted");

endmodule
